// ----- sv/ptpc_pkg.sv -----
package ptpc_pkg;

  // Item field widths
  localparam int VER_W     = 10;
  localparam int LETTERS_W = 50;
  localparam int LETTER_W  = 5;
  localparam int LEN_W     = 4;
  localparam int COUNT_W   = 11;

  // Letter slots addressable by a level counter of LEN_W bits
  localparam int MAX_SLOTS = 1 << LEN_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // Result status codes
  localparam logic STATUS_DONE   = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic clr;       // clear one version root entry
    logic latch;     // capture the input transaction
    logic root_rd;   // read the root table, evaluate rejection
    logic fetch;     // start the walk at the selected root
    logic step;      // process one trie level
    logic load_out;  // move the result into the output register
  } ptpc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic reject;
    logic step_last;
  } ptpc_sts_t;

endpackage

// ----- sv/ptpc_ctrl.sv -----
module ptpc_ctrl import ptpc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  ptpc_sts_t sts_i,
  output ptpc_cmd_t cmd_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ROOT  = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_STEP  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // Clear the root table after reset, then sequence each transaction through root lookup, level walk and result
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_ROOT;
        end
      end
      S_ROOT: begin
        cmd_o.root_rd = 1'b1;
        state_d       = sts_i.reject ? S_FIN : S_FETCH;
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = S_STEP;
      end
      S_STEP: begin
        cmd_o.step = 1'b1;
        if (sts_i.step_last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- sv/ptpc_dp.sv -----
module ptpc_dp import ptpc_pkg::*; #(
  parameter int NODE_POOL   = 4096,
  parameter int ALPHABET    = 26,
  parameter int MAX_LETTERS = 10,
  parameter int VERSIONS    = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ptpc_cmd_t            cmd_i,
  output ptpc_sts_t            sts_o,
  input  logic                 cmd_in_i,
  input  logic [VER_W-1:0]     version_i,
  input  logic [VER_W-1:0]     base_version_i,
  input  logic [LETTERS_W-1:0] letters_i,
  input  logic [LEN_W-1:0]     word_length_i,
  output logic [COUNT_W-1:0]   prefix_count_o,
  output logic                 status_o
);

  localparam int NW     = $clog2(NODE_POOL);
  localparam int VW     = $clog2(VERSIONS);
  localparam int AW     = $clog2(ALPHABET);
  localparam int KIDS_W = ALPHABET * NW;
  localparam int ROW_W  = KIDS_W + COUNT_W;
  localparam int EXT_W  = LETTER_W * MAX_SLOTS;

  // Node rows: all children and the count of one node per entry
  logic [ROW_W-1:0] row_mem [NODE_POOL];
  logic [NW-1:0]    root_mem [VERSIONS];

  // Latched transaction
  logic                 cmd_q;
  logic [VER_W-1:0]     ver_q, base_q;
  logic [LETTERS_W-1:0] letters_q;
  logic [LEN_W-1:0]     len_q;

  // Walk state
  logic [LEN_W-1:0]   lvl_q;
  logic [NW-1:0]      last_q, node_q, root_new_q;
  logic [NW:0]        nfree_q;
  logic [VW-1:0]      clr_q;
  logic [NW-1:0]      root_rd_q;
  logic               root_ok_q;
  logic [ROW_W-1:0]   rdata_q;
  logic [COUNT_W-1:0] res_count_q, prefix_count_q;
  logic               res_status_q, status_q;

  logic [EXT_W-1:0]                 ext;
  logic [LETTER_W-1:0]              cur_letter;
  logic [AW-1:0]                    cidx;
  logic                             letter_ok, bad_letter, pool_full, reject;
  logic [31:0]                      ver32, base32, nfree32;
  logic                             ver_ok, base_ok, is_insert, lvl_last, base_null;
  logic [VW-1:0]                    ridx;
  logic                             rok;
  logic [NW-1:0]                    root_sel, child_next, raddr;
  logic [ALPHABET-1:0][NW-1:0]      base_kids, new_kids;
  logic [COUNT_W-1:0]               base_cnt, new_cnt;
  logic                             row_we, row_re, commit, step_last;

  // Decode the latched transaction
  assign ext        = EXT_W'(letters_q);
  assign cur_letter = ext[lvl_q*LETTER_W +: LETTER_W];
  assign letter_ok  = int'(cur_letter) < ALPHABET;
  assign cidx       = cur_letter[AW-1:0];
  assign is_insert  = (cmd_q == CMD_INSERT);
  assign ver32      = 32'(ver_q);
  assign base32     = 32'(base_q);
  assign nfree32    = 32'(nfree_q);
  assign ver_ok     = ver32 < 32'(VERSIONS);
  assign base_ok    = base32 < 32'(VERSIONS);
  assign lvl_last   = (lvl_q == len_q);

  // Flag any out-of-alphabet letter inside the word
  always_comb begin
    bad_letter = 1'b0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if ((LEN_W'(i) < len_q) && (int'(ext[i*LETTER_W +: LETTER_W]) >= ALPHABET)) begin
        bad_letter = 1'b1;
      end
    end
  end

  assign pool_full = (nfree32 >= 32'(NODE_POOL)) ||
                     ((32'(NODE_POOL) - nfree32) < (32'(len_q) + 32'd1));
  assign reject    = is_insert && (!ver_ok || bad_letter || pool_full);

  // Root table index: query reads its own version, insert its base
  assign ridx     = is_insert ? base32[VW-1:0] : ver32[VW-1:0];
  assign rok      = is_insert ? base_ok : ver_ok;
  assign root_sel = root_ok_q ? root_rd_q : '0;

  // Unpack the base row; the null node reads as empty
  assign base_null = (last_q == '0);
  assign base_kids = base_null ? '0 : rdata_q[KIDS_W-1:0];
  assign base_cnt  = base_null ? '0 : rdata_q[ROW_W-1 -: COUNT_W];
  assign child_next = letter_ok ? base_kids[cidx] : '0;

  // Build the copied row with the new child link
  always_comb begin
    new_kids = base_kids;
    if (!lvl_last) begin
      new_kids[cidx] = nfree_q[NW-1:0];
    end
  end

  assign new_cnt = (lvl_q == '0) ? '0 :
                   ((base_cnt == COUNT_MAX) ? COUNT_MAX : base_cnt + COUNT_W'(1));

  assign row_we    = cmd_i.step && is_insert;
  assign row_re    = cmd_i.fetch || cmd_i.step;
  assign raddr     = cmd_i.fetch ? root_sel : child_next;
  assign commit    = cmd_i.step && is_insert && lvl_last;
  assign step_last = lvl_last || (!is_insert && base_null);

  assign sts_o.clr_last  = (clr_q == VW'(VERSIONS - 1));
  assign sts_o.reject    = reject;
  assign sts_o.step_last = step_last;

  // Node row memory
  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem[node_q] <= {new_cnt, new_kids};
    end
    if (row_re) begin
      rdata_q <= row_mem[raddr];
    end
  end

  // Version root memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      root_mem[clr_q] <= '0;
    end else if (commit) begin
      root_mem[ver32[VW-1:0]] <= root_new_q;
    end
    if (cmd_i.root_rd) begin
      root_rd_q <= root_mem[ridx];
    end
  end

  // Allocation pointer and clearing counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nfree_q <= (NW+1)'(1);
      clr_q   <= '0;
    end else begin
      if (cmd_i.clr && !sts_o.clr_last) begin
        clr_q <= clr_q + VW'(1);
      end
      if ((cmd_i.fetch && is_insert) || (cmd_i.step && is_insert && !lvl_last)) begin
        nfree_q <= nfree_q + (NW+1)'(1);
      end
    end
  end

  // Transaction, walk and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q     <= cmd_in_i;
      ver_q     <= version_i;
      base_q    <= base_version_i;
      letters_q <= letters_i;
      len_q     <= (int'(word_length_i) > MAX_LETTERS) ? LEN_W'(MAX_LETTERS) : word_length_i;
    end
    if (cmd_i.root_rd) begin
      root_ok_q    <= rok;
      res_status_q <= reject ? STATUS_REJECT : STATUS_DONE;
      res_count_q  <= '0;
    end
    if (cmd_i.fetch) begin
      last_q     <= root_sel;
      node_q     <= nfree_q[NW-1:0];
      root_new_q <= nfree_q[NW-1:0];
      lvl_q      <= '0;
    end
    if (cmd_i.step) begin
      if (step_last) begin
        if (!is_insert) begin
          res_count_q <= base_cnt;
        end
      end else begin
        last_q <= child_next;
        node_q <= nfree_q[NW-1:0];
        lvl_q  <= lvl_q + LEN_W'(1);
      end
    end
    if (cmd_i.load_out) begin
      prefix_count_q <= res_count_q;
      status_q       <= res_status_q;
    end
  end

  assign prefix_count_o = prefix_count_q;
  assign status_o       = status_q;

endmodule

// ----- sv/persistent_trie_prefix_count.sv -----
// Versioned path-copying trie with prefix counts.
// Input channel (in_valid_i / in_stall_o) carries one command per transaction:
// insert (cmd 0) builds a new version from a base version plus one word,
// query (cmd 1) counts the words of a version that carry a prefix.
// Output channel (out_valid_o / out_stall_i) returns one result per
// transaction: prefix_count_o (zero for inserts) and status_o (1 when an
// insert is rejected for a full pool, a bad letter or a bad version).
// The walk covers the trie levels of the word length, clamped to MAX_LETTERS
// letters; a query whose path runs into the null node finishes early.
// Each trie level reads the base row and, for an insert, writes the copied
// row.
// One transaction is in flight at a time; the next is taken once the result
// sits in the output register, even while the receiver still stalls it.
// A stalled result holds until taken, and the block waits for it before
// delivering the following one.
// After reset the version root table is cleared, one entry a cycle, through all
// VERSIONS entries (1024 by default); in_stall_o stays high meanwhile.
module persistent_trie_prefix_count import ptpc_pkg::*; #(
  parameter int NODE_POOL   = 4096,
  parameter int ALPHABET    = 26,
  parameter int MAX_LETTERS = 10,
  parameter int VERSIONS    = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 cmd_i,
  input  logic [VER_W-1:0]     version_i,
  input  logic [VER_W-1:0]     base_version_i,
  input  logic [LETTERS_W-1:0] letters_i,
  input  logic [LEN_W-1:0]     word_length_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [COUNT_W-1:0]   prefix_count_o,
  output logic                 status_o
);

  ptpc_cmd_t cmd;
  ptpc_sts_t sts;

  ptpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ptpc_dp #(
    .NODE_POOL   (NODE_POOL),
    .ALPHABET    (ALPHABET),
    .MAX_LETTERS (MAX_LETTERS),
    .VERSIONS    (VERSIONS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cmd_in_i       (cmd_i),
    .version_i      (version_i),
    .base_version_i (base_version_i),
    .letters_i      (letters_i),
    .word_length_i  (word_length_i),
    .prefix_count_o (prefix_count_o),
    .status_o       (status_o)
  );

  // Controller issues at most one command per cycle
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clr, cmd.latch, cmd.root_rd, cmd.fetch, cmd.step, cmd.load_out}))
    else $error("more than one datapath command in a cycle");

  // Stop stepping once the last level is processed
  a_step_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.step && sts.step_last) |=> !cmd.step)
    else $error("walk continued past its last level");

  // A loaded result is presented on the next cycle
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> out_valid_o)
    else $error("result loaded but not presented");

  // Accepting a transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (in_stall_o && !cmd.latch))
    else $error("second transaction taken while one is in flight");

endmodule
